FILE: hdl/cpu_8bit_load_unit_defines.svh
// Assertion macros for the 8-bit load unit.
// No dependencies; included by the top level.
`ifndef CPU_8BIT_LOAD_UNIT_DEFINES_SVH
`define CPU_8BIT_LOAD_UNIT_DEFINES_SVH

`ifndef SYNTH
`define CUL_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("load unit check failed");
`define CUL_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("load unit check failed");
`else
`define CUL_ASSERT_IMP(lbl, ante, cons)
`define CUL_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/cul_pkg.sv
// Types, opcodes and register indexes of the 8-bit load unit.
// No dependencies; imported by cpu_8bit_load_unit.
package cul_pkg;

   typedef logic [2:0] idx_type;

   localparam idx_type IDX_B = 3'd0;
   localparam idx_type IDX_C = 3'd1;
   localparam idx_type IDX_D = 3'd2;
   localparam idx_type IDX_E = 3'd3;
   localparam idx_type IDX_H = 3'd4;
   localparam idx_type IDX_L = 3'd5;
   localparam idx_type IDX_A = 3'd6;
   localparam idx_type IDX_NONE = 3'd7;
   localparam int RF_DEPTH = 7;

   // operand codes in the opcode byte
   localparam logic [2:0] CODE_MEM = 3'd6;
   localparam logic [2:0] CODE_A = 3'd7;

   localparam logic [15:0] HIGH_PAGE = 16'hFF00;

   localparam logic [7:0] OP_MOVE_LO   = 8'h40;
   localparam logic [7:0] OP_MOVE_HI   = 8'h7F;
   localparam logic [7:0] OP_HALT      = 8'h76;
   localparam logic [7:0] OP_ST_BC     = 8'h02;
   localparam logic [7:0] OP_ST_DE     = 8'h12;
   localparam logic [7:0] OP_ST_HLI    = 8'h22;
   localparam logic [7:0] OP_ST_HLD    = 8'h32;
   localparam logic [7:0] OP_LD_BC     = 8'h0A;
   localparam logic [7:0] OP_LD_DE     = 8'h1A;
   localparam logic [7:0] OP_LD_HLI    = 8'h2A;
   localparam logic [7:0] OP_LD_HLD    = 8'h3A;
   localparam logic [7:0] OP_ST_HIGH_N = 8'hE0;
   localparam logic [7:0] OP_ST_HIGH_C = 8'hE2;
   localparam logic [7:0] OP_ST_ABS    = 8'hEA;
   localparam logic [7:0] OP_LD_HIGH_N = 8'hF0;
   localparam logic [7:0] OP_LD_HIGH_C = 8'hF2;
   localparam logic [7:0] OP_LD_ABS    = 8'hFA;

   localparam logic FUNC_INSTR = 1'b0;
   localparam logic FUNC_RDATA = 1'b1;

   // input word, last field in the lowest bits
   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] imm_hi;
      logic [7:0] imm_lo;
      logic [7:0] opcode;
   } req_type;

   // result word, last field in the lowest bits
   typedef struct packed {
      logic [4:0]  pad;
      logic [15:0] reg_hl;
      logic [15:0] reg_de;
      logic [15:0] reg_bc;
      logic [7:0]  reg_acc;
      logic        unsupported;
      logic [7:0]  mem_wdata;
      logic [15:0] mem_address;
      logic        mem_write;
      logic        mem_valid;
   } rsp_type;

   function automatic idx_type code_to_index(input logic [2:0] code);
      return (code == CODE_A) ? IDX_A : idx_type'(code);
   endfunction

endpackage

FILE: hdl/cpu_8bit_load_unit.sv
// Top level of the 8-bit load unit: input register, decode and register file, result register.
// Depends on cul_pkg and cpu_8bit_load_unit_defines.svh.
//
// channel  dir  tdata                                             tuser
// req      in   opcode, imm_lo, imm_hi, read_data                 func
// rsp      out  mem_valid, mem_write, mem_address, mem_wdata,     -
//               unsupported, reg_acc, reg_bc, reg_de, reg_hl
//
// One word per cycle while rsp is not stalled; a taken word passes the input register, then the result register.
// The limit is the register file update, done once per word in the decode stage.
// Reset clears the register file, the pending read and both stage valids.
// A stalled rsp holds its word; req keeps taking a word while the input register can move on.
`include "cpu_8bit_load_unit_defines.svh"

module cpu_8bit_load_unit
   import cul_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // opcode, imm_lo, imm_hi, read_data
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata    // mem_valid, mem_write, mem_address, mem_wdata,
                                    // unsupported, reg_acc, reg_bc, reg_de, reg_hl, zero pad
);

   logic        s1_valid_ff, s1_valid_in;
   req_type     s1_data_ff;
   logic        s1_func_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [7:0]  rf_ff [RF_DEPTH];
   logic [7:0]  rf_in [RF_DEPTH];
   logic        pending_ff, pending_in;
   idx_type     target_ff, target_in;

   logic        req_take;
   logic        rsp_load;

   logic [7:0]  op;
   logic [2:0]  dcode, scode;
   logic [15:0] hl, hl_inc, hl_dec;
   logic        acc_valid, acc_write, supported, is_read;
   logic [15:0] acc_addr;
   logic [7:0]  acc_wdata;
   idx_type     rd_target;

   assign rsp_load   = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || rsp_load;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in  = req_take ? 1'b1 : (rsp_load ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   assign op     = s1_data_ff.opcode;
   assign dcode  = op[5:3];
   assign scode  = op[2:0];
   assign hl     = {rf_ff[IDX_H], rf_ff[IDX_L]};
   assign hl_inc = hl + 16'd1;
   assign hl_dec = hl - 16'd1;

   always_comb begin
      rf_in      = rf_ff;
      pending_in = pending_ff;
      target_in  = target_ff;
      acc_valid  = 1'b0;
      acc_write  = 1'b0;
      acc_addr   = 16'd0;
      acc_wdata  = 8'd0;
      supported  = 1'b1;
      is_read    = 1'b0;
      rd_target  = IDX_B;

      if (s1_func_ff == FUNC_RDATA) begin
         // returned byte with nothing pending is dropped
         if (pending_ff) begin
            if (target_ff != IDX_NONE) begin
               rf_in[target_ff] = s1_data_ff.read_data;
            end
            pending_in = 1'b0;
         end
      end else begin
         if (op inside {[OP_MOVE_LO:OP_MOVE_HI]} && op != OP_HALT) begin
            if (scode == CODE_MEM) begin
               is_read   = 1'b1;
               acc_addr  = hl;
               rd_target = code_to_index(dcode);
            end else if (dcode == CODE_MEM) begin
               acc_valid = 1'b1;
               acc_write = 1'b1;
               acc_addr  = hl;
               acc_wdata = rf_ff[code_to_index(scode)];
            end else begin
               rf_in[code_to_index(dcode)] = rf_ff[code_to_index(scode)];
            end
         end else if (op[7:6] == 2'b00 && scode == CODE_MEM) begin
            if (dcode == CODE_MEM) begin
               acc_valid = 1'b1;
               acc_write = 1'b1;
               acc_addr  = hl;
               acc_wdata = s1_data_ff.imm_lo;
            end else begin
               rf_in[code_to_index(dcode)] = s1_data_ff.imm_lo;
            end
         end else begin
            rd_target = IDX_A;
            case (op)
               OP_ST_BC: begin
                  acc_valid = 1'b1;
                  acc_write = 1'b1;
                  acc_addr  = {rf_ff[IDX_B], rf_ff[IDX_C]};
                  acc_wdata = rf_ff[IDX_A];
               end
               OP_ST_DE: begin
                  acc_valid = 1'b1;
                  acc_write = 1'b1;
                  acc_addr  = {rf_ff[IDX_D], rf_ff[IDX_E]};
                  acc_wdata = rf_ff[IDX_A];
               end
               OP_ST_HLI: begin
                  acc_valid = 1'b1;
                  acc_write = 1'b1;
                  acc_addr  = hl;
                  acc_wdata = rf_ff[IDX_A];
                  {rf_in[IDX_H], rf_in[IDX_L]} = hl_inc;
               end
               OP_ST_HLD: begin
                  acc_valid = 1'b1;
                  acc_write = 1'b1;
                  acc_addr  = hl;
                  acc_wdata = rf_ff[IDX_A];
                  {rf_in[IDX_H], rf_in[IDX_L]} = hl_dec;
               end
               OP_LD_BC: begin
                  is_read  = 1'b1;
                  acc_addr = {rf_ff[IDX_B], rf_ff[IDX_C]};
               end
               OP_LD_DE: begin
                  is_read  = 1'b1;
                  acc_addr = {rf_ff[IDX_D], rf_ff[IDX_E]};
               end
               OP_LD_HLI: begin
                  is_read  = 1'b1;
                  acc_addr = hl;
                  {rf_in[IDX_H], rf_in[IDX_L]} = hl_inc;
               end
               OP_LD_HLD: begin
                  is_read  = 1'b1;
                  acc_addr = hl;
                  {rf_in[IDX_H], rf_in[IDX_L]} = hl_dec;
               end
               OP_ST_HIGH_N: begin
                  acc_valid = 1'b1;
                  acc_write = 1'b1;
                  acc_addr  = HIGH_PAGE | {8'd0, s1_data_ff.imm_lo};
                  acc_wdata = rf_ff[IDX_A];
               end
               OP_ST_HIGH_C: begin
                  acc_valid = 1'b1;
                  acc_write = 1'b1;
                  acc_addr  = HIGH_PAGE | {8'd0, rf_ff[IDX_C]};
                  acc_wdata = rf_ff[IDX_A];
               end
               OP_ST_ABS: begin
                  acc_valid = 1'b1;
                  acc_write = 1'b1;
                  acc_addr  = {s1_data_ff.imm_hi, s1_data_ff.imm_lo};
                  acc_wdata = rf_ff[IDX_A];
               end
               OP_LD_HIGH_N: begin
                  is_read  = 1'b1;
                  acc_addr = HIGH_PAGE | {8'd0, s1_data_ff.imm_lo};
               end
               OP_LD_HIGH_C: begin
                  is_read  = 1'b1;
                  acc_addr = HIGH_PAGE | {8'd0, rf_ff[IDX_C]};
               end
               OP_LD_ABS: begin
                  is_read  = 1'b1;
                  acc_addr = {s1_data_ff.imm_hi, s1_data_ff.imm_lo};
               end
               default: begin
                  supported = 1'b0;
               end
            endcase
         end

         // a supported instruction cancels any pending read
         if (supported) begin
            pending_in = 1'b0;
            if (is_read) begin
               acc_valid  = 1'b1;
               acc_write  = 1'b0;
               acc_wdata  = 8'd0;
               pending_in = 1'b1;
               target_in  = rd_target;
            end
         end
      end

      rsp_data_in.pad         = '0;
      rsp_data_in.mem_valid   = acc_valid;
      rsp_data_in.mem_write   = acc_valid && acc_write;
      rsp_data_in.mem_address = acc_valid ? acc_addr : 16'd0;
      rsp_data_in.mem_wdata   = (acc_valid && acc_write) ? acc_wdata : 8'd0;
      rsp_data_in.unsupported = !supported;
      rsp_data_in.reg_acc     = rf_in[IDX_A];
      rsp_data_in.reg_bc      = {rf_in[IDX_B], rf_in[IDX_C]};
      rsp_data_in.reg_de      = {rf_in[IDX_D], rf_in[IDX_E]};
      rsp_data_in.reg_hl      = {rf_in[IDX_H], rf_in[IDX_L]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= 1'b0;
         target_ff    <= IDX_B;
         for (int i = 0; i < RF_DEPTH; i++) begin
            rf_ff[i] <= 8'd0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // commit state only as the word moves into the result register
         if (rsp_load) begin
            pending_ff <= pending_in;
            target_ff  <= target_in;
            rf_ff      <= rf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_tdata;
         s1_func_ff <= req_tuser;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `CUL_ASSERT_IMP(a_stall_blocks_input, s1_valid_ff && rsp_valid_ff && !rsp_tready, !req_tready)
   `CUL_ASSERT_NXT(a_read_goes_pending, rsp_load && rsp_data_in.mem_valid && !rsp_data_in.mem_write, pending_ff && rsp_valid_ff)
   `CUL_ASSERT_NXT(a_unsup_keeps_acc, rsp_load && rsp_data_in.unsupported, rsp_data_ff.reg_acc == $past(rf_ff[IDX_A]) && !rsp_data_ff.mem_valid)
   `CUL_ASSERT_NXT(a_rdata_clears_pending, rsp_load && s1_func_ff == FUNC_RDATA, !pending_ff && !rsp_data_ff.mem_valid)

endmodule

FILE: tb/sv/tb_cpu_8bit_load_unit.sv
// Testbench for cpu_8bit_load_unit: a directed table, then random instruction and read-data words,
// every result checked against its typed value or an in-bench model of the load group.
// Depends on cul_pkg and the cpu_8bit_load_unit RTL.
`timescale 1ns / 100ps

module tb_cpu_8bit_load_unit;
   import cul_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_WORDS = 700;
   localparam int IDLE_PCT = 24;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int TAIL_CYCLES = 20;

   localparam logic TYPED = 1'b1;
   localparam logic PREDICTED = 1'b0;

   // register operand codes not named by the package
   localparam logic [2:0] CODE_B = 3'd0;
   localparam logic [2:0] CODE_C = 3'd1;
   localparam logic [2:0] CODE_H = 3'd4;
   localparam logic [2:0] CODE_L = 3'd5;

   localparam logic [7:0] OP_LD_B_N = {2'b00, CODE_B, CODE_MEM};
   localparam logic [7:0] OP_LD_C_N = {2'b00, CODE_C, CODE_MEM};
   localparam logic [7:0] OP_LD_H_N = {2'b00, CODE_H, CODE_MEM};
   localparam logic [7:0] OP_LD_L_N = {2'b00, CODE_L, CODE_MEM};
   localparam logic [7:0] OP_LD_A_N = {2'b00, CODE_A, CODE_MEM};
   localparam logic [7:0] OP_ST_M_N = {2'b00, CODE_MEM, CODE_MEM};
   localparam logic [7:0] OP_LD_H_M = {2'b01, CODE_H, CODE_MEM};
   localparam logic [7:0] OP_LD_L_M = {2'b01, CODE_L, CODE_MEM};
   localparam logic [7:0] OP_ST_M_B = {2'b01, CODE_MEM, CODE_B};
   localparam logic [7:0] OP_MV_A_H = {2'b01, CODE_A, CODE_H};
   localparam logic [7:0] OP_NOP    = 8'h00;
   localparam logic [7:0] OP_PREFIX = 8'hCB;
   localparam logic [7:0] OP_RST38  = 8'hFF;

   typedef struct packed {
      logic    func;
      req_type w;
      logic    typed;
      rsp_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // opcode, imm_lo, imm_hi, read_data
   logic        req_tuser = 1'b0;  // func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;         // mem_valid, mem_write, mem_address, mem_wdata,
                                   // unsupported, reg_acc, reg_bc, reg_de, reg_hl, zero pad

   // model state: B, C, D, E, H, L, A
   logic [7:0] cpu_regs [RF_DEPTH];
   logic       rd_pending;
   idx_type    rd_target;

   rsp_type      expected_rsp [$];
   stim_row_type dir_table [$];
   logic [7:0] group_ops [14] = '{OP_ST_BC, OP_ST_DE, OP_ST_HLI, OP_ST_HLD, OP_LD_BC, OP_LD_DE,
                                  OP_LD_HLI, OP_LD_HLD, OP_ST_HIGH_N, OP_ST_HIGH_C, OP_ST_ABS,
                                  OP_LD_HIGH_N, OP_LD_HIGH_C, OP_LD_ABS};

   int      cycle_count = 0;
   int      results_seen = 0;
   int      mismatches = 0;
   int      counted = 0;
   logic    held_off = 1'b0;
   rsp_type got_rsp;
   rsp_type want_rsp;

   cpu_8bit_load_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic idx_type operand_reg(input logic [2:0] code);
      return (code == CODE_A) ? IDX_A : idx_type'(code);
   endfunction

   function automatic logic [15:0] reg_pair(input idx_type hi, input idx_type lo);
      return {cpu_regs[hi], cpu_regs[lo]};
   endfunction

   // Advance the model by one accepted word and return the result it causes.
   function automatic rsp_type predict_load(input logic func, input req_type w);
      rsp_type     r;
      logic [15:0] hl;
      logic [7:0]  acc;
      logic [2:0]  dst;
      logic [2:0]  src;
      logic        is_rd;
      logic        ok;
      idx_type     tgt;
      r = '0;
      hl = reg_pair(IDX_H, IDX_L);
      acc = cpu_regs[IDX_A];
      dst = w.opcode[5:3];
      src = w.opcode[2:0];
      is_rd = 1'b0;
      ok = 1'b1;
      tgt = IDX_A;
      if (func == FUNC_RDATA) begin
         if (rd_pending) begin
            cpu_regs[rd_target] = w.read_data;
            rd_pending = 1'b0;
         end
      end else begin
         if (w.opcode >= OP_MOVE_LO && w.opcode <= OP_MOVE_HI && w.opcode != OP_HALT) begin
            if (src == CODE_MEM) begin
               is_rd = 1'b1;
               r.mem_address = hl;
               tgt = operand_reg(dst);
            end else if (dst == CODE_MEM) begin
               r.mem_valid = 1'b1;
               r.mem_write = 1'b1;
               r.mem_address = hl;
               r.mem_wdata = cpu_regs[operand_reg(src)];
            end else begin
               cpu_regs[operand_reg(dst)] = cpu_regs[operand_reg(src)];
            end
         end else if (w.opcode < OP_MOVE_LO && src == CODE_MEM) begin
            if (dst == CODE_MEM) begin
               r.mem_valid = 1'b1;
               r.mem_write = 1'b1;
               r.mem_address = hl;
               r.mem_wdata = w.imm_lo;
            end else begin
               cpu_regs[operand_reg(dst)] = w.imm_lo;
            end
         end else begin
            r.mem_wdata = acc;
            r.mem_write = 1'b1;
            case (w.opcode)
               OP_ST_BC:     r.mem_address = reg_pair(IDX_B, IDX_C);
               OP_ST_DE:     r.mem_address = reg_pair(IDX_D, IDX_E);
               OP_ST_HLI: begin
                  r.mem_address = hl;
                  {cpu_regs[IDX_H], cpu_regs[IDX_L]} = hl + 16'd1;
               end
               OP_ST_HLD: begin
                  r.mem_address = hl;
                  {cpu_regs[IDX_H], cpu_regs[IDX_L]} = hl - 16'd1;
               end
               OP_ST_HIGH_N: r.mem_address = HIGH_PAGE | {8'd0, w.imm_lo};
               OP_ST_HIGH_C: r.mem_address = HIGH_PAGE | {8'd0, cpu_regs[IDX_C]};
               OP_ST_ABS:    r.mem_address = {w.imm_hi, w.imm_lo};
               OP_LD_BC: begin
                  is_rd = 1'b1;
                  r.mem_address = reg_pair(IDX_B, IDX_C);
               end
               OP_LD_DE: begin
                  is_rd = 1'b1;
                  r.mem_address = reg_pair(IDX_D, IDX_E);
               end
               OP_LD_HLI: begin
                  is_rd = 1'b1;
                  r.mem_address = hl;
                  {cpu_regs[IDX_H], cpu_regs[IDX_L]} = hl + 16'd1;
               end
               OP_LD_HLD: begin
                  is_rd = 1'b1;
                  r.mem_address = hl;
                  {cpu_regs[IDX_H], cpu_regs[IDX_L]} = hl - 16'd1;
               end
               OP_LD_HIGH_N: begin
                  is_rd = 1'b1;
                  r.mem_address = HIGH_PAGE | {8'd0, w.imm_lo};
               end
               OP_LD_HIGH_C: begin
                  is_rd = 1'b1;
                  r.mem_address = HIGH_PAGE | {8'd0, cpu_regs[IDX_C]};
               end
               OP_LD_ABS: begin
                  is_rd = 1'b1;
                  r.mem_address = {w.imm_hi, w.imm_lo};
               end
               default: begin
                  ok = 1'b0;
                  r.mem_address = '0;
               end
            endcase
            r.mem_valid = ok;
            r.mem_write = ok;
            if (!ok) r.mem_wdata = '0;
         end
         if (!ok) begin
            r.unsupported = 1'b1;
         end else begin
            rd_pending = 1'b0;
            if (is_rd) begin
               r.mem_valid = 1'b1;
               r.mem_write = 1'b0;
               r.mem_wdata = '0;
               rd_pending = 1'b1;
               rd_target = tgt;
            end
         end
      end
      r.reg_acc = cpu_regs[IDX_A];
      r.reg_bc = reg_pair(IDX_B, IDX_C);
      r.reg_de = reg_pair(IDX_D, IDX_E);
      r.reg_hl = reg_pair(IDX_H, IDX_L);
      return r;
   endfunction

   function automatic rsp_type typed_rsp(input logic valid, input logic write,
                                         input logic [15:0] addr, input logic [7:0] wdata,
                                         input logic unsup, input logic [7:0] acc,
                                         input logic [15:0] bc, input logic [15:0] de,
                                         input logic [15:0] hl);
      rsp_type r;
      r = '0;
      r.mem_valid = valid;
      r.mem_write = write;
      r.mem_address = addr;
      r.mem_wdata = wdata;
      r.unsupported = unsup;
      r.reg_acc = acc;
      r.reg_bc = bc;
      r.reg_de = de;
      r.reg_hl = hl;
      return r;
   endfunction

   task automatic add_row(input logic func, input logic [7:0] op, input logic [7:0] lo,
                          input logic [7:0] hi, input logic [7:0] rd, input logic typed,
                          input rsp_type want);
      stim_row_type s;
      s.func = func;
      s.w = {rd, hi, lo, op};
      s.typed = typed;
      s.want = want;
      dir_table.push_back(s);
   endtask

   function automatic string fmt_rsp(input rsp_type r);
      return $sformatf("valid %b wr %b addr %h wdata %h unsup %b a %h bc %h de %h hl %h pad %h",
                       r.mem_valid, r.mem_write, r.mem_address, r.mem_wdata, r.unsupported,
                       r.reg_acc, r.reg_bc, r.reg_de, r.reg_hl, r.pad);
   endfunction

   task automatic log_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch (%s) at cycle %0d", what, cycle_count);
         $display("   expected %s", fmt_rsp(want));
         $display("   actual   %s", fmt_rsp(got));
      end
   endtask

   // Offer one word, wait for the handshake, then record what it should produce.
   task automatic offer_word(input logic func, input req_type w, input logic may_idle,
                             input logic typed, input rsp_type want);
      rsp_type p;
      while (may_idle && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= w;
      do @(posedge clock); while (!req_tready);
      p = predict_load(func, w);
      expected_rsp.push_back(typed ? want : p);
      @(negedge clock);
   endtask

   // Mostly well-formed traffic: reads are usually answered, with stray data and odd opcodes.
   task automatic pick_word(output logic func, output req_type w);
      w = req_type'($urandom);
      func = FUNC_INSTR;
      if (rd_pending && $urandom_range(99) < 80) begin
         func = FUNC_RDATA;
      end else if ($urandom_range(99) < 6) begin
         func = FUNC_RDATA;
      end else begin
         case ($urandom_range(9))
            0, 1, 2, 3: w.opcode = 8'($urandom_range(OP_MOVE_LO, OP_MOVE_HI));
            4, 5:       w.opcode = {2'b00, 3'($urandom_range(7)), CODE_MEM};
            6, 7, 8:    w.opcode = group_ops[$urandom_range(13)];
            default:    w.opcode = 8'($urandom);
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp = rsp_type'(rsp_tdata);
         results_seen++;
         if (expected_rsp.size() == 0) begin
            log_mismatch("no result expected", '0, got_rsp);
         end else begin
            want_rsp = expected_rsp.pop_front();
            if (got_rsp.mem_valid !== want_rsp.mem_valid ||
                got_rsp.mem_write !== want_rsp.mem_write ||
                got_rsp.mem_address !== want_rsp.mem_address ||
                got_rsp.mem_wdata !== want_rsp.mem_wdata ||
                got_rsp.unsupported !== want_rsp.unsupported ||
                got_rsp.reg_acc !== want_rsp.reg_acc ||
                got_rsp.reg_bc !== want_rsp.reg_bc ||
                got_rsp.reg_de !== want_rsp.reg_de ||
                got_rsp.reg_hl !== want_rsp.reg_hl ||
                got_rsp.pad !== want_rsp.pad)
               log_mismatch("field", want_rsp, got_rsp);
         end
      end
   end

   // Result side: random stalls, one long hold-off, and a stretch that never stalls.
   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!held_off && results_seen >= 150) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_tready <= (results_seen >= 500 && results_seen < 650) ||
                       ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      logic    func;
      req_type w;
      logic    drained;
      drained = 1'b0;
      foreach (cpu_regs[i]) cpu_regs[i] = 8'h00;
      rd_pending = 1'b0;
      rd_target = IDX_B;

      // from reset: outside the group, immediate A, absolute store, data with nothing pending
      add_row(FUNC_INSTR, OP_HALT, 8'h00, 8'h00, 8'h00, TYPED,
              typed_rsp(0, 0, 16'h0000, 8'h00, 1, 8'h00, 16'h0000, 16'h0000, 16'h0000));
      add_row(FUNC_INSTR, OP_LD_A_N, 8'hFF, 8'h00, 8'h00, TYPED,
              typed_rsp(0, 0, 16'h0000, 8'h00, 0, 8'hFF, 16'h0000, 16'h0000, 16'h0000));
      add_row(FUNC_INSTR, OP_ST_ABS, 8'h34, 8'h12, 8'hFF, TYPED,
              typed_rsp(1, 1, 16'h1234, 8'hFF, 0, 8'hFF, 16'h0000, 16'h0000, 16'h0000));
      add_row(FUNC_RDATA, OP_NOP, 8'hFF, 8'hFF, 8'h5A, TYPED,
              typed_rsp(0, 0, 16'h0000, 8'h00, 0, 8'hFF, 16'h0000, 16'h0000, 16'h0000));
      add_row(FUNC_INSTR, OP_RST38, 8'hFF, 8'hFF, 8'hFF, TYPED,
              typed_rsp(0, 0, 16'h0000, 8'h00, 1, 8'hFF, 16'h0000, 16'h0000, 16'h0000));
      // HL wraps both ways, loads into H and L through HL
      add_row(FUNC_INSTR, OP_LD_H_N, 8'hFF, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_INSTR, OP_LD_L_N, 8'hFF, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_INSTR, OP_ST_HLI, 8'h00, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_INSTR, OP_ST_HLD, 8'h00, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_INSTR, OP_LD_H_M, 8'h00, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_RDATA, OP_NOP, 8'h00, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_INSTR, OP_LD_L_M, 8'h00, 8'h00, 8'h00, PREDICTED, '0);
      // a new read replaces the pending one; an unsupported opcode leaves it pending
      add_row(FUNC_INSTR, OP_LD_HLI, 8'h00, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_INSTR, OP_PREFIX, 8'h00, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_RDATA, OP_NOP, 8'h00, 8'h00, 8'h80, PREDICTED, '0);
      add_row(FUNC_INSTR, OP_LD_ABS, 8'hFF, 8'hFF, 8'h00, PREDICTED, '0);
      add_row(FUNC_INSTR, OP_LD_B_N, 8'h00, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_RDATA, OP_NOP, 8'h00, 8'h00, 8'hAA, PREDICTED, '0);
      add_row(FUNC_INSTR, OP_LD_C_N, 8'h80, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_INSTR, OP_LD_HIGH_C, 8'h00, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_RDATA, OP_NOP, 8'h00, 8'h00, 8'h01, PREDICTED, '0);
      add_row(FUNC_INSTR, OP_ST_HIGH_C, 8'h00, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_INSTR, OP_LD_HIGH_N, 8'h00, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_RDATA, OP_NOP, 8'h00, 8'h00, 8'hFF, PREDICTED, '0);
      add_row(FUNC_INSTR, OP_ST_HIGH_N, 8'hFF, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_INSTR, OP_ST_M_N, 8'hA5, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_INSTR, OP_ST_M_B, 8'h00, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_INSTR, OP_MV_A_H, 8'h00, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_INSTR, OP_ST_BC, 8'h00, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_INSTR, OP_LD_DE, 8'h00, 8'h00, 8'h00, PREDICTED, '0);
      add_row(FUNC_RDATA, OP_NOP, 8'h00, 8'h00, 8'h3C, PREDICTED, '0);

      wait (!reset);
      foreach (dir_table[i])
         offer_word(dir_table[i].func, dir_table[i].w, 1'b1, dir_table[i].typed,
                    dir_table[i].want);

      while (counted < RANDOM_WORDS) begin
         // hold the sender once until the block has drained
         if (counted >= 350 && !drained) begin
            drained = 1'b1;
            req_tvalid <= 1'b0;
            while (expected_rsp.size() != 0) @(negedge clock);
         end
         pick_word(func, w);
         if (!(func == FUNC_RDATA && !rd_pending)) counted++;
         offer_word(func, w, !(counted >= 450 && counted < 600), PREDICTED, '0);
      end
      req_tvalid <= 1'b0;

      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/cul_pkg.sv
hdl/cpu_8bit_load_unit.sv
tb/sv/tb_cpu_8bit_load_unit.sv
